>>> design/rbst_pkg.sv
package rbst_pkg;

  // Default coordinate width: signed Q16.16.
  localparam int unsigned COORD_BITS_DEF = 32;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_FIELDS = 12;

  // Position of the first (x) field of each group in the input word.
  localparam int unsigned FIELD_ORIGIN  = 0;
  localparam int unsigned FIELD_INV_DIR = 3;
  localparam int unsigned FIELD_BOX_LO  = 6;
  localparam int unsigned FIELD_BOX_HI  = 9;

  // Register stages from input to the output register.
  localparam int unsigned NUM_STAGES = 5;

  // The one-bit result padded to a whole byte.
  localparam int unsigned OUT_TDATA_W = 8;

  // Per-stage load enables; s1 sits in the lowest bit.
  typedef struct packed {
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } pipe_en_t;

endpackage

>>> design/rbst_mul.sv
module rbst_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 32
) (
  input  logic                    clk_i,
  input  rbst_pkg::pipe_en_t      en_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] prod_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned LA = AW / 2;
  localparam int unsigned HA = AW - LA;
  localparam int unsigned LB = BW / 2;
  localparam int unsigned HB = BW - LB;

  logic [LA-1:0] a_lo;
  logic [HA-1:0] a_hi;
  logic [LB-1:0] b_lo;
  logic [HB-1:0] b_hi;

  logic signed [HA+HB-1:0]   pp_hh_q;
  logic signed [HA+LB:0]     pp_hl_q;
  logic signed [LA+HB:0]     pp_lh_q;
  logic        [LA+LB-1:0]   pp_ll_q;

  logic [PW-1:0] hh_x;
  logic [PW-1:0] hl_x;
  logic [PW-1:0] lh_x;
  logic [PW-1:0] ll_x;
  logic [PW-1:0] sum;
  logic [PW-1:0] prod_q;

  assign a_lo = a_i[LA-1:0];
  assign a_hi = a_i[AW-1:LA];
  assign b_lo = b_i[LB-1:0];
  assign b_hi = b_i[BW-1:LB];

  // Stage 2: four narrow partial products; the low halves are unsigned.
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pp_hh_q <= (HA+HB)'($signed(a_hi)) * (HA+HB)'($signed(b_hi));
      pp_hl_q <= (HA+LB+1)'($signed(a_hi)) * (HA+LB+1)'($signed({1'b0, b_lo}));
      pp_lh_q <= (LA+HB+1)'($signed({1'b0, a_lo})) * (LA+HB+1)'($signed(b_hi));
      pp_ll_q <= (LA+LB)'(a_lo) * (LA+LB)'(b_lo);
    end
  end

  // Stage 3: align and add. The exact product fits in PW bits, so the sum
  // taken modulo 2^PW is the exact signed result.
  always_comb begin
    hh_x = {{(PW-HA-HB){pp_hh_q[HA+HB-1]}}, pp_hh_q};
    hl_x = {{(PW-HA-LB-1){pp_hl_q[HA+LB]}}, pp_hl_q};
    lh_x = {{(PW-LA-HB-1){pp_lh_q[LA+HB]}}, pp_lh_q};
    ll_x = {{(PW-LA-LB){1'b0}}, pp_ll_q};
    sum  = (hh_x << (LA + LB)) + (hl_x << LA) + (lh_x << LB) + ll_x;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      prod_q <= sum;
    end
  end

  assign prod_o = $signed(prod_q);

endmodule

>>> design/rbst_axis.sv
module rbst_axis #(
  parameter int unsigned COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  rbst_pkg::pipe_en_t           en_i,
  input  logic signed [COORD_BITS-1:0] origin_i,
  input  logic signed [COORD_BITS-1:0] inv_dir_i,
  input  logic signed [COORD_BITS-1:0] box_lo_i,
  input  logic signed [COORD_BITS-1:0] box_hi_i,
  output logic signed [2*COORD_BITS:0] near_o,
  output logic signed [2*COORD_BITS:0] far_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = DW + COORD_BITS;

  logic signed [DW-1:0]         diff_lo_q;
  logic signed [DW-1:0]         diff_hi_q;
  logic signed [COORD_BITS-1:0] inv_q;
  logic signed [PW-1:0]         dist_lo;
  logic signed [PW-1:0]         dist_hi;
  logic signed [PW-1:0]         near_q;
  logic signed [PW-1:0]         far_q;

  // Stage 1: slab offsets, one bit wider than the coordinates.
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      diff_lo_q <= {box_lo_i[COORD_BITS-1], box_lo_i} - {origin_i[COORD_BITS-1], origin_i};
      diff_hi_q <= {box_hi_i[COORD_BITS-1], box_hi_i} - {origin_i[COORD_BITS-1], origin_i};
      inv_q     <= inv_dir_i;
    end
  end

  // Stages 2 and 3: exact distances to both slab planes.
  rbst_mul #(
    .AW (DW),
    .BW (COORD_BITS)
  ) u_mul_lo (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (diff_lo_q),
    .b_i    (inv_q),
    .prod_o (dist_lo)
  );

  rbst_mul #(
    .AW (DW),
    .BW (COORD_BITS)
  ) u_mul_hi (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (diff_hi_q),
    .b_i    (inv_q),
    .prod_o (dist_hi)
  );

  // Stage 4: order the pair, since a negative direction or swapped corners
  // put the planes the other way round.
  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      if (dist_hi < dist_lo) begin
        near_q <= dist_hi;
        far_q  <= dist_lo;
      end else begin
        near_q <= dist_lo;
        far_q  <= dist_hi;
      end
    end
  end

  assign near_o = near_q;
  assign far_o  = far_q;

endmodule

>>> design/rbst_hit.sv
module rbst_hit #(
  parameter int unsigned COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  rbst_pkg::pipe_en_t           en_i,
  input  logic signed [2*COORD_BITS:0] near_i [rbst_pkg::NUM_AXES],
  input  logic signed [2*COORD_BITS:0] far_i  [rbst_pkg::NUM_AXES],
  output logic                         hit_o
);

  localparam int unsigned PW = 2 * COORD_BITS + 1;

  logic hit;
  logic hit_q;

  // The smallest exit is at least the largest of the entries and zero
  // exactly when every exit clears every entry and zero, so all the
  // comparisons run side by side instead of as a fold.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < int'(rbst_pkg::NUM_AXES); i++) begin
      hit = hit & ~far_i[i][PW-1];
      for (int j = 0; j < int'(rbst_pkg::NUM_AXES); j++) begin
        hit = hit & ~(far_i[i] < near_i[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      hit_q <= hit;
    end
  end

  assign hit_o = hit_q;

endmodule

>>> design/ray_box_slab_test.sv
// Channel  Direction  Word contents (lowest bits first)
// s_axis   in         origin xyz, inv_dir xyz, box_lo xyz, box_hi xyz, zero pad to bytes
// m_axis   out        hit, zero pad to one byte
//
// A new word can be taken in every cycle unless all stages are full and m_axis stalls.
// A word taken at a clock edge fills the first of five register stages at that edge,
// and its result is offered on m_axis once it reaches the last stage. The depth is set
// by the slab subtract, the split multiplier (partial products, then their sum), the
// near/far ordering and the final comparison stage, which is also the output register.
// Each stage holds its word while the one after it is full and stalled, so
// the input keeps accepting until all five stages are occupied.
// Reset is asynchronous and active low; it empties the pipeline and holds
// s_axis_tready low until the first clock edge after it is released.
module ray_box_slab_test #(
  parameter int unsigned  COORD_BITS = rbst_pkg::COORD_BITS_DEF,
  localparam int unsigned InW        = ((rbst_pkg::NUM_FIELDS * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OutW       = rbst_pkg::OUT_TDATA_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,

  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
  // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z, zero pad
  input  logic [InW-1:0] s_axis_tdata,

  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // hit, zero pad
  output logic [OutW-1:0] m_axis_tdata
);

  localparam int unsigned PW     = 2 * COORD_BITS + 1;
  localparam int unsigned Stages = rbst_pkg::NUM_STAGES;

  logic [Stages-1:0]  valid_q;
  logic [Stages-1:0]  valid_d;
  logic [Stages-1:0]  stage_en;
  logic               run_q;
  logic               in_acc;
  logic               out_acc;
  logic               hit;
  rbst_pkg::pipe_en_t en;

  logic signed [PW-1:0] near [rbst_pkg::NUM_AXES];
  logic signed [PW-1:0] far  [rbst_pkg::NUM_AXES];

  // A stage may load when it is empty or when the stage after it is moving
  // on in the same cycle. The last stage is the output register.
  always_comb begin
    stage_en[Stages-1] = ~valid_q[Stages-1] | m_axis_tready;
    for (int k = int'(Stages) - 2; k >= 0; k--) begin
      stage_en[k] = ~valid_q[k] | stage_en[k+1];
    end
  end

  assign en            = rbst_pkg::pipe_en_t'(stage_en);
  assign s_axis_tready = run_q & stage_en[0];
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = m_axis_tvalid & m_axis_tready;

  // Valid bits follow their words down the pipeline.
  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = s_axis_tvalid & run_q;
    end
    for (int k = 1; k < int'(Stages); k++) begin
      if (stage_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      run_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      run_q   <= 1'b1;
    end
  end

  // One slab unit per axis: offsets, exact distances, near/far ordering.
  for (genvar a = 0; a < int'(rbst_pkg::NUM_AXES); a++) begin : g_axis
    rbst_axis #(
      .COORD_BITS (COORD_BITS)
    ) u_axis (
      .clk_i     (clk_i),
      .en_i      (en),
      .origin_i  ($signed(s_axis_tdata[(rbst_pkg::FIELD_ORIGIN + a) * COORD_BITS +: COORD_BITS])),
      .inv_dir_i ($signed(s_axis_tdata[(rbst_pkg::FIELD_INV_DIR + a) * COORD_BITS +: COORD_BITS])),
      .box_lo_i  ($signed(s_axis_tdata[(rbst_pkg::FIELD_BOX_LO + a) * COORD_BITS +: COORD_BITS])),
      .box_hi_i  ($signed(s_axis_tdata[(rbst_pkg::FIELD_BOX_HI + a) * COORD_BITS +: COORD_BITS])),
      .near_o    (near[a]),
      .far_o     (far[a])
    );
  end

  // Entry/exit comparison into the output register.
  rbst_hit #(
    .COORD_BITS (COORD_BITS)
  ) u_hit (
    .clk_i  (clk_i),
    .en_i   (en),
    .near_i (near),
    .far_i  (far),
    .hit_o  (hit)
  );

  assign m_axis_tvalid = valid_q[Stages-1];
  assign m_axis_tdata  = {{(OutW-1){1'b0}}, hit};

`ifndef SYNTHESIS
  // Words in flight change only by what is taken in and what is handed out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> $countones(valid_q) ==
      $countones($past(valid_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline occupancy does not match the handshakes");

  // With any stage free the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !(&valid_q)) |-> s_axis_tready)
    else $error("input stalled while the pipeline has room");

  // A stage that holds a word and may not load keeps that word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> ((valid_q & $past(valid_q & ~stage_en)) == $past(valid_q & ~stage_en)))
    else $error("a stalled stage dropped its word");
`endif

endmodule
